// ===== rtl/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg: shared types for the modular inverse block
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take a new operand pair
    logic grow;     // double the shifted divisor
    logic shrink;   // trial subtract, then halve or swap
    logic capture;  // write the result into the output register
  } mie_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic r1_zero;  // remainder sequence has ended
    logic grow_ok;  // doubled divisor still fits under the remainder
    logic k_zero;   // divisor is back at its unshifted value
  } mie_sts_t;

endpackage

// ===== rtl/modular_inverse_ext_euclid_top.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top: modular inverse by extended Euclid
// Returns the inverse of value modulo modulus, or zero with exists clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries value_i and modulus_i.
//   Output channel (out_valid_o / out_ready_i) carries inverse_value_o and
//   exists_o, one result per input item, in order.
//   Each Euclid division runs as a shift-and-subtract loop: a grow phase
//   doubles the divisor, then a shrink phase trial-subtracts it back down.
//   A value above the modulus adds one swap step.
//   One item is in flight at a time; in_ready_o rises when the result is
//   written into the output register.
//   A result waits in the output register while the receiver stalls; the
//   input side accepts and processes the next item meanwhile and holds its
//   result until the register is free.
//   Reset clears the sequencer and the output valid; no item is pending.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] inverse_value_o,
  output logic             exists_o
);
  import mie_pkg::*;

  mie_cmd_t cmd;
  mie_sts_t sts;

  mie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mie_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .modulus_i      (modulus_i),
    .inverse_value_o(inverse_value_o),
    .exists_o       (exists_o)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is being worked on");
`endif

endmodule

// ===== rtl/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mie_ctrl: sequencer for the modular inverse block
// Steps the datapath through grow and shrink phases of each Euclid division
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mie_pkg::mie_sts_t sts_i,
  output mie_pkg::mie_cmd_t cmd_o
);
  import mie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_GROW   = 4'b0010,
    S_SHRINK = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GROW;
        end
      end
      S_GROW: begin
        if (sts_i.r1_zero) begin
          state_d = S_FINISH;
        end else if (sts_i.grow_ok) begin
          cmd_o.grow = 1'b1;
        end else begin
          state_d = S_SHRINK;
        end
      end
      S_SHRINK: begin
        cmd_o.shrink = 1'b1;
        if (sts_i.k_zero) begin
          state_d = S_GROW;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Set on capture, drop on output transfer
  assign out_valid_d = cmd_o.capture | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_starts_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_GROW))
    else $error("accepted item did not start the division loop");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && !out_ready_i) |=>
      (state_q == S_FINISH && out_valid_q))
    else $error("result overwrote an untaken output");
`endif

endmodule

// ===== rtl/mie_dp.sv =====
// ----------------------------------------------------------------------------
// mie_dp: datapath of the modular inverse block
// Remainder pair, Bezout coefficient pair, shifted divisor and coefficient,
// and the normalizing stage that writes the output register.
// ----------------------------------------------------------------------------
module mie_dp #(
  parameter int WIDTH = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mie_pkg::mie_cmd_t cmd_i,
  output mie_pkg::mie_sts_t sts_o,
  input  logic [WIDTH-1:0]  value_i,
  input  logic [WIDTH-1:0]  modulus_i,
  output logic [WIDTH-1:0]  inverse_value_o,
  output logic              exists_o
);
  import mie_pkg::*;

  localparam int TW = WIDTH + 2;
  localparam int KW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] m_q, r0_q, r0_d, r1_q, r1_d, d_q, d_d;
  logic [TW-1:0]    t0_q, t0_d, t1_q, t1_d, td_q, td_d;
  logic [KW-1:0]    k_q, k_d;
  logic             mzero_q;
  logic [WIDTH-1:0] inv_q;
  logic             exists_q;

  logic             sub_ok;
  logic [WIDTH-1:0] rem_new;
  logic [TW-1:0]    t_new;

  // Trial subtract of the shifted divisor
  assign sub_ok  = (d_q <= r0_q);
  assign rem_new = sub_ok ? (r0_q - d_q) : r0_q;
  assign t_new   = sub_ok ? (t0_q - td_q) : t0_q;

  // Status back to the controller
  assign sts_o.r1_zero = (r1_q == '0);
  assign sts_o.grow_ok = ({d_q, 1'b0} <= {1'b0, r0_q});
  assign sts_o.k_zero  = (k_q == '0);

  // Division step registers; hold everything when no command is issued
  always_comb begin
    r0_d = r0_q;
    r1_d = r1_q;
    d_d  = d_q;
    t0_d = t0_q;
    t1_d = t1_q;
    td_d = td_q;
    k_d  = k_q;
    if (cmd_i.load) begin
      r0_d = modulus_i;
      r1_d = value_i;
      d_d  = value_i;
      t0_d = '0;
      t1_d = TW'(1);
      td_d = TW'(1);
      k_d  = '0;
    end else if (cmd_i.grow) begin
      d_d  = {d_q[WIDTH-2:0], 1'b0};
      td_d = {td_q[TW-2:0], 1'b0};
      k_d  = k_q + KW'(1);
    end else if (cmd_i.shrink) begin
      if (k_q == '0) begin
        // quotient done: rotate the pairs
        r0_d = r1_q;
        r1_d = rem_new;
        d_d  = rem_new;
        t0_d = t1_q;
        t1_d = t_new;
        td_d = t_new;
      end else begin
        r0_d = rem_new;
        t0_d = t_new;
        d_d  = {1'b0, d_q[WIDTH-1:1]};
        td_d = {td_q[TW-1], td_q[TW-1:1]};
        k_d  = k_q - KW'(1);
      end
    end
  end

  // Normalize the coefficient into 0 .. modulus-1
  logic [TW-1:0]    m_ext, t_plus, t_minus;
  logic             t_neg, t_ge;
  logic [WIDTH-1:0] inv_d;
  logic             exists_d;

  assign m_ext    = {2'b00, m_q};
  assign t_neg    = t0_q[TW-1];
  assign t_plus   = t0_q + m_ext;
  assign t_minus  = t0_q - m_ext;
  assign t_ge     = !t_neg && (t0_q >= m_ext);
  assign exists_d = !mzero_q && (r0_q == WIDTH'(1));

  always_comb begin
    priority if (!exists_d || m_q == WIDTH'(1)) begin
      inv_d = '0;
    end else if (t_neg) begin
      inv_d = t_plus[WIDTH-1:0];
    end else if (t_ge) begin
      inv_d = t_minus[WIDTH-1:0];
    end else begin
      inv_d = t0_q[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
    d_q  <= d_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    td_q <= td_d;
    if (cmd_i.load) begin
      m_q     <= modulus_i;
      mzero_q <= (modulus_i == '0);
    end
    if (cmd_i.capture) begin
      inv_q    <= inv_d;
      exists_q <= exists_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  assign inverse_value_o = inv_q;
  assign exists_o        = exists_q;

`ifndef SYNTHESIS
  a_divisor_restored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shrink && k_q == '0) |-> (d_q == r1_q))
    else $error("shifted divisor not back at the divisor on the last step");

  a_inverse_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> (!exists_q || inv_q < m_q || m_q == '0))
    else $error("inverse not reduced below the modulus");
`endif

endmodule
